// ===== sv/slab_object_allocator_unit_macros.svh =====
// Assertion macros shared by the slab allocator RTL.
`ifndef SLAB_OBJECT_ALLOCATOR_UNIT_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked every cycle outside reset.
`define SOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/soa_pkg.sv =====
// Package with the slab allocator's shared types and constants.
package soa_pkg;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;
  localparam int DESC_BYTES = 40;
  localparam int LINK_BYTES = 4;
  localparam int SLOT_SPACE = 256;
  localparam int SLOT_W     = 8;
  localparam int CLASS_W    = 3;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  frame;
    logic [7:0]  slot;
    logic [11:0] offset;
    logic [2:0]  cls;
  } soa_result_t;

  // Per-frame bookkeeping word: owner class, live object count and free-list head.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [8:0]         live;
    logic [SLOT_W-1:0]  head;
  } frame_rec_t;
endpackage

// ===== sv/soa_chain_ram.sv =====
// Next-free slot store: one write port, one registered read port.
module soa_chain_ram import soa_pkg::*; #(
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SLOT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SLOT_W-1:0] rd_data
);
  logic [SLOT_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/slab_object_allocator_unit.sv =====
// Top level of the slab object allocator with its sequencer.
// Command interface: a request beat is taken when start is high and busy is low; the
// result appears for exactly one cycle with out_valid, and the receiver cannot stall it.
// After the accepting edge, an allocate from a partial slab passes S_RD, S_RDW, S_POP and
// S_DONE before the result strobe; a free passes S_FRD, S_FCHK and S_DONE, with S_FPUSH
// before S_DONE when a full slab goes back on a non-empty partial list; a request rejected
// on the spot (size too large or free of an idle frame) goes straight to S_DONE. Busy stays
// high through the strobe cycle, so the next beat is taken only after the strobe. An
// allocate that opens a new slab first scans frames for the lowest idle one, one frame per
// cycle, then writes the new slab's next-free chain one entry per cycle, because the chain
// store has a single write port. Per-frame state lives in small memories with registered
// reads, which is why reads pass through the wait states S_RD/S_RDW and S_FRD.
// Requests are served strictly one at a time. There is no clearing pass after reset.
`include "slab_object_allocator_unit_macros.svh"
module slab_object_allocator_unit import soa_pkg::*; #(
  parameter int FRAME_COUNT = 64,
  parameter int PAGE_BYTES  = 4096,
  parameter int CLASS_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [15:0] in_request_size,
  input  logic [5:0]  in_frame_number,
  input  logic [7:0]  in_object_slot,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_granted_frame,
  output logic [7:0]  out_granted_slot,
  output logic [11:0] out_byte_offset,
  output logic [2:0]  out_size_class,
  output logic [6:0]  out_frames_in_use
);
  localparam int FW   = $clog2(FRAME_COUNT);
  localparam int LW   = FW + 1;
  localparam int AW   = FW + SLOT_W;
  localparam int CW   = $clog2(FRAME_COUNT + 1);
  localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);

  // Per-class table of objects per slab and object base offset, elaborated from params.
  // Object sizes are powers of two, so the divisions are shifts.
  function automatic int f_ops(int c);
    int n;
    n = (PAGE_BYTES - DESC_BYTES) >> (c + 4);
    n = n - ((n * LINK_BYTES + (16 << c) - 1) >> (c + 4));
    return (n > SLOT_SPACE) ? SLOT_SPACE : n;
  endfunction

  logic [8:0]  ops_tab  [CLASS_COUNT];
  logic [15:0] base_tab [CLASS_COUNT];
  for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_tab
    assign ops_tab[g]  = 9'(f_ops(g));
    assign base_tab[g] = 16'((DESC_BYTES + LINK_BYTES * f_ops(g) + 7) & ~7);
  end

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHAIN, S_RD, S_RDW, S_POP, S_FRD, S_FCHK, S_FPUSH, S_DONE
  } state_t;

  state_t                 state_r;
  logic [FRAME_COUNT-1:0] fbusy_r;
  frame_rec_t             ftab_mem  [FRAME_COUNT];
  logic [LW-1:0]          pnext_mem [FRAME_COUNT];
  logic [LW-1:0]          pprev_mem [FRAME_COUNT];
  frame_rec_t             ftab_rd_r;
  logic [LW-1:0]          pnext_rd_r;
  logic [LW-1:0]          pprev_rd_r;
  logic [LW-1:0]          phead_r  [CLASS_COUNT];
  logic [CW-1:0]          total_r;
  logic [FW-1:0]          f_r;
  logic [CLASS_W-1:0]     c_r;
  logic [8:0]             i_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [LW-1:0]          h_r;
  soa_result_t            res_r;
  logic                   vld_r;

  logic              ram_we;
  logic [AW-1:0]     ram_wa, ram_ra;
  logic [SLOT_W-1:0] ram_wd, ram_rd;

  soa_chain_ram #(.ADDR_W(AW)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  // The frame memories are always read at the frame under work; the read data is registered.
  always_ff @(posedge clk) begin
    ftab_rd_r  <= ftab_mem[f_r];
    pnext_rd_r <= pnext_mem[f_r];
    pprev_rd_r <= pprev_mem[f_r];
  end

  // Size class search: a compare per class, independent of each other.
  logic [3:0] req_cls;
  always_comb begin
    req_cls = 4'(CLASS_COUNT);
    for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
      if (32'(in_request_size) <= (32'd16 << k)) begin
        req_cls = 4'(k);
      end
    end
  end

  logic [8:0] ops_c;
  assign ops_c = ops_tab[c_r];

  // Class and capacity of the frame being freed, valid once its record is read back.
  logic [CLASS_W-1:0] fr_cls;
  logic [8:0]         fr_ops;
  logic               fchk_ok;
  assign fr_cls  = ftab_rd_r.cls;
  assign fr_ops  = ops_tab[fr_cls];
  assign fchk_ok = (9'(slot_r) < fr_ops);

  always_comb begin
    ram_we = 1'b0;
    ram_wa = {f_r, i_r[SLOT_W-1:0]};
    ram_wd = SLOT_W'(i_r + 9'd1);
    ram_ra = {f_r, ftab_rd_r.head};
    if (state_r == S_CHAIN) begin
      ram_we = 1'b1;
    end else if (state_r == S_FCHK && fchk_ok) begin
      ram_we = 1'b1;
      ram_wa = {f_r, slot_r};
      ram_wd = ftab_rd_r.head;
    end
  end

  // A free is only taken further when the frame exists and holds a slab.
  logic fr_ok;
  assign fr_ok = (32'(in_frame_number) < FRAME_COUNT) && fbusy_r[FW'(in_frame_number)];

  logic [8:0]    live_nxt;
  logic [LW-1:0] up, un;
  assign live_nxt = ftab_rd_r.live + 9'd1;
  assign up       = pprev_rd_r;
  assign un       = pnext_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fbusy_r <= '0;
      total_r <= '0;
      vld_r   <= 1'b0;
      for (int k = 0; k < CLASS_COUNT; k++) phead_r[k] <= NIL;
    end else begin
      vld_r <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            if (!in_kind) begin
              if (req_cls >= 4'(CLASS_COUNT) || ops_tab[req_cls[CLASS_W-1:0]] == 9'd0) begin
                res_r   <= '{status: ST_TOO_BIG, default: '0};
                state_r <= S_DONE;
              end else begin
                res_r <= '0;
                c_r   <= req_cls[CLASS_W-1:0];
                i_r   <= '0;
                if (phead_r[req_cls[CLASS_W-1:0]] == NIL) begin
                  f_r <= '0;
                  state_r <= S_SCAN;
                end else begin
                  f_r <= FW'(phead_r[req_cls[CLASS_W-1:0]]);
                  state_r <= S_RD;
                end
              end
            end else begin
              f_r    <= FW'(in_frame_number);
              slot_r <= in_object_slot;
              if (!fr_ok) begin
                res_r   <= '{status: ST_BAD_FREE, default: '0};
                state_r <= S_DONE;
              end else begin
                res_r   <= '0;
                state_r <= S_FRD;
              end
            end
          end
        end
        S_SCAN: begin
          if (!fbusy_r[f_r]) begin
            fbusy_r[f_r]   <= 1'b1;
            ftab_mem[f_r]  <= '{cls: c_r, live: '0, head: '0};
            total_r        <= total_r + 1'b1;
            pnext_mem[f_r] <= phead_r[c_r];
            pprev_mem[f_r] <= NIL;
            phead_r[c_r]   <= LW'(f_r);
            state_r <= S_CHAIN;
          end else if (32'(f_r) == FRAME_COUNT - 1) begin
            res_r.status <= ST_NO_FRAME;
            state_r <= S_DONE;
          end else begin
            f_r <= f_r + 1'b1;
          end
        end
        S_CHAIN: begin
          i_r <= i_r + 9'd1;
          if (i_r + 9'd1 >= ops_c) state_r <= S_RD;
        end
        S_RD:  state_r <= S_RDW;
        S_RDW: state_r <= S_POP;
        S_POP: begin
          ftab_mem[f_r] <= '{cls: c_r, live: live_nxt, head: ram_rd};
          if (live_nxt >= ops_c) begin
            if (up == NIL) phead_r[c_r] <= un;
            else pnext_mem[FW'(up)] <= un;
            if (un != NIL) pprev_mem[FW'(un)] <= up;
          end
          res_r.frame  <= 6'(f_r);
          res_r.slot   <= ftab_rd_r.head;
          res_r.offset <= 12'(base_tab[c_r] + 16'(ftab_rd_r.head) * (16'd16 << c_r));
          res_r.cls    <= c_r;
          state_r <= S_DONE;
        end
        S_FRD: state_r <= S_FCHK;
        S_FCHK: begin
          if (!fchk_ok) begin
            res_r.status <= ST_BAD_FREE;
            state_r <= S_DONE;
          end else if (ftab_rd_r.live <= 9'd1) begin
            // The slab is empty now, so its frame goes back to the pool.
            ftab_mem[f_r] <= '{cls: fr_cls, live: '0, head: slot_r};
            if (ftab_rd_r.live < fr_ops) begin
              if (up == NIL) phead_r[fr_cls] <= un;
              else pnext_mem[FW'(up)] <= un;
              if (un != NIL) pprev_mem[FW'(un)] <= up;
            end
            fbusy_r[f_r] <= 1'b0;
            total_r <= total_r - 1'b1;
            state_r <= S_DONE;
          end else begin
            ftab_mem[f_r] <= '{cls: fr_cls, live: ftab_rd_r.live - 9'd1, head: slot_r};
            if (ftab_rd_r.live == fr_ops) begin
              // A full slab regains room and goes to the head of its partial list; the
              // old head's back link is written in the next cycle.
              pnext_mem[f_r]  <= phead_r[fr_cls];
              pprev_mem[f_r]  <= NIL;
              h_r             <= phead_r[fr_cls];
              phead_r[fr_cls] <= LW'(f_r);
              if (phead_r[fr_cls] != NIL) state_r <= S_FPUSH;
              else state_r <= S_DONE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_FPUSH: begin
          pprev_mem[FW'(h_r)] <= LW'(f_r);
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE) || vld_r;
  assign out_valid         = vld_r;
  assign out_status        = res_r.status;
  assign out_granted_frame = res_r.frame;
  assign out_granted_slot  = res_r.slot;
  assign out_byte_offset   = res_r.offset;
  assign out_size_class    = res_r.cls;
  assign out_frames_in_use = 7'(total_r);

  `SOA_ASSERT_IMP(a_total_range, clk, rst_n, 1'b1, 32'(total_r) <= FRAME_COUNT)
  `SOA_ASSERT_NEXT(a_valid_pulse, clk, rst_n, vld_r, !vld_r)
  `SOA_ASSERT_IMP(a_ok_in_range, clk, rst_n, vld_r && out_status == ST_OK,
                  32'(out_size_class) < CLASS_COUNT)
endmodule

// ===== dv/slab_object_allocator_unit_tb.sv =====
// Self-checking testbench for the slab object allocator with its own allocator predictor.
`timescale 1ns / 1ps
module slab_object_allocator_unit_tb;
  import soa_pkg::*;

  localparam int NFRAMES   = 64;
  localparam int NCLASSES  = 6;
  localparam int PAGE      = 4096;
  localparam int NIL       = NFRAMES;
  localparam int IDLE_MAX  = 4000;   // cycles with no beat on either side before giving up
  localparam int QUIET_TAIL = 150;   // last requests are sent back to back
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [5:0]  frame;
    logic [7:0]  slot;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  frame;
    logic [7:0]  slot;
    logic [11:0] offset;
    logic [2:0]  cls;
    logic [6:0]  in_use;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = KIND_ALLOC;
  logic [15:0] in_request_size = '0;
  logic [5:0]  in_frame_number = '0;
  logic [7:0]  in_object_slot = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_granted_frame;
  logic [7:0]  out_granted_slot;
  logic [11:0] out_byte_offset;
  logic [2:0]  out_size_class;
  logic [6:0]  out_frames_in_use;

  slab_object_allocator_unit dut (.*);

  always #5 clk = ~clk;

  // Requests waiting to be sent, grants the allocator still owes us, and the objects
  // the predictor believes are handed out (frame in the high bits, slot in the low).
  request_t    pending_reqs[$];
  grant_t      owed_grants[$];
  logic [13:0] live_objs[$];
  int          fail_count = 0;
  bit          quiet = 1'b0;

  // Shadow copy of the allocator's bookkeeping.
  bit       sh_busy[NFRAMES];
  int       sh_owner[NFRAMES];
  int       sh_live[NFRAMES];
  int       sh_head[NFRAMES];
  int       sh_chain[NFRAMES * SLOT_SPACE];
  int       sh_part_head[NCLASSES];
  int       sh_part_next[NFRAMES];
  int       sh_part_prev[NFRAMES];
  int       sh_total;

  // Objects that fit in one slab of a class after the descriptor and the link words.
  function automatic int slab_capacity(int c);
    int sz, n;
    sz = 16 << c;
    n = (PAGE - DESC_BYTES) / sz;
    n -= (n * LINK_BYTES + sz - 1) / sz;
    return (n > SLOT_SPACE) ? SLOT_SPACE : n;
  endfunction

  function automatic void partial_remove(int f);
    int p, n;
    p = sh_part_prev[f];
    n = sh_part_next[f];
    if (p == NIL) sh_part_head[sh_owner[f]] = n;
    else sh_part_next[p] = n;
    if (n != NIL) sh_part_prev[n] = p;
  endfunction

  function automatic void partial_insert(int f);
    int n;
    n = sh_part_head[sh_owner[f]];
    sh_part_next[f] = n;
    sh_part_prev[f] = NIL;
    if (n != NIL) sh_part_prev[n] = f;
    sh_part_head[sh_owner[f]] = f;
  endfunction

  // Apply one request to the shadow state and return the grant it should produce.
  function automatic grant_t serve_request(logic kind, logic [15:0] size,
                                           logic [5:0] fr, logic [7:0] sl);
    grant_t g;
    int c, cap, f, i, slot, prior;
    g = '{ST_OK, '0, '0, '0, '0, '0};
    if (kind == KIND_ALLOC) begin
      c = 0;
      while (c < NCLASSES && int'(size) > (16 << c)) c++;
      if (c >= NCLASSES || slab_capacity(c) == 0) begin
        g.status = ST_TOO_BIG;
      end else begin
        cap = slab_capacity(c);
        f = sh_part_head[c];
        if (f == NIL) begin
          // Open a new slab on the lowest idle frame and chain all of its objects.
          for (i = 0; i < NFRAMES && sh_busy[i]; i++) ;
          if (i < NFRAMES) begin
            f = i;
            sh_busy[f] = 1'b1;
            sh_owner[f] = c;
            sh_live[f] = 0;
            sh_head[f] = 0;
            for (i = 0; i < cap; i++) sh_chain[f * SLOT_SPACE + i] = (i + 1) & 8'hFF;
            sh_total++;
            partial_insert(f);
          end
        end
        if (f == NIL) begin
          g.status = ST_NO_FRAME;
        end else begin
          slot = sh_head[f];
          sh_live[f]++;
          sh_head[f] = sh_chain[f * SLOT_SPACE + slot];
          if (sh_live[f] >= cap) partial_remove(f);
          g.frame = 6'(f);
          g.slot = 8'(slot);
          g.offset = 12'(((DESC_BYTES + LINK_BYTES * cap + 7) & ~7) + slot * (16 << c));
          g.cls = 3'(c);
          live_objs.push_back({g.frame, g.slot});
        end
      end
    end else begin
      f = int'(fr);
      if (!sh_busy[f] || int'(sl) >= slab_capacity(sh_owner[f])) begin
        g.status = ST_BAD_FREE;
      end else begin
        cap = slab_capacity(sh_owner[f]);
        prior = sh_live[f];
        sh_chain[f * SLOT_SPACE + int'(sl)] = sh_head[f];
        sh_head[f] = int'(sl);
        sh_live[f] = prior - 1;
        if (prior <= 1) begin
          // The slab is empty now, so its frame goes back to the pool.
          if (prior < cap) partial_remove(f);
          sh_busy[f] = 1'b0;
          sh_live[f] = 0;
          sh_total--;
        end else if (prior == cap) begin
          partial_insert(f);
        end
      end
    end
    g.in_use = sh_total[6:0];
    return g;
  endfunction

  // Driver: a beat is taken at an edge where start is high and busy is low. The next
  // request is put up in the same edge, so start stays high across back-to-back beats
  // and gets a single nonblocking assignment per edge.
  int gap_left = 0;
  always @(posedge clk) begin
    logic     start_next;
    request_t rq;
    if (rst_n) begin
      start_next = start;
      if (start && !busy) begin
        owed_grants.push_back(serve_request(in_kind, in_request_size,
                                            in_frame_number, in_object_slot));
        start_next = 1'b0;
      end
      if (!start_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          rq = pending_reqs.pop_front();
          in_kind         <= rq.kind;
          in_request_size <= rq.size;
          in_frame_number <= rq.frame;
          in_object_slot  <= rq.slot;
          start_next = 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
        end
      end
      start <= start_next;
    end
  end

  // Monitor: every strobed result is matched against the oldest owed grant.
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid) begin
      if (owed_grants.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        g = owed_grants.pop_front();
        if (out_status !== g.status) begin
          $error("status: expected %0d, actual %0d", g.status, out_status);
          fail_count++;
        end
        if (out_granted_frame !== g.frame) begin
          $error("granted_frame: expected %0d, actual %0d", g.frame, out_granted_frame);
          fail_count++;
        end
        if (out_granted_slot !== g.slot) begin
          $error("granted_slot: expected %0d, actual %0d", g.slot, out_granted_slot);
          fail_count++;
        end
        if (out_byte_offset !== g.offset) begin
          $error("byte_offset: expected %0d, actual %0d", g.offset, out_byte_offset);
          fail_count++;
        end
        if (out_size_class !== g.cls) begin
          $error("size_class: expected %0d, actual %0d", g.cls, out_size_class);
          fail_count++;
        end
        if (out_frames_in_use !== g.in_use) begin
          $error("frames_in_use: expected %0d, actual %0d", g.in_use, out_frames_in_use);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a slab opening costs a frame scan plus a chain walk, both bounded,
  // so a long stretch with no beat at all means the block hung.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_alloc(int size);
    pending_reqs.push_back('{KIND_ALLOC, size[15:0], 6'($urandom), 8'($urandom)});
  endtask

  task automatic send_free(int fr, int sl);
    pending_reqs.push_back('{KIND_FREE, 16'($urandom), fr[5:0], sl[7:0]});
  endtask

  // Free a random live object, or a random frame and slot when none is known.
  task automatic send_live_free();
    int k;
    logic [13:0] obj;
    if (live_objs.size() == 0) begin
      send_free($urandom_range(0, 63), $urandom_range(0, 255));
    end else begin
      k = $urandom_range(0, live_objs.size() - 1);
      obj = live_objs[k];
      live_objs.delete(k);
      send_free(obj[13:8], obj[7:0]);
    end
  endtask

  // Random size within a random class of the range, with edges of each class.
  function automatic int pick_size(int lo_cls, int hi_cls);
    int c;
    c = $urandom_range(lo_cls, hi_cls);
    case ($urandom_range(0, 3))
      0: return 16 << c;
      1: return (c == 0) ? 0 : (8 << c) + 1;
      default: return $urandom_range((c == 0) ? 0 : (8 << c) + 1, 16 << c);
    endcase
  endfunction

  // Stimulus. Each round has its own mix so the pool both fills to exhaustion and
  // drains back to empty, with every class opening and releasing slabs along the way.
  initial begin
    int round, n, total, sent, r;
    int round_len[4]   = '{300, 450, 300, 200};
    int alloc_pct[4]   = '{60, 92, 20, 50};
    int lo_cls[4]      = '{0, 5, 0, 0};
    rst_n = 1'b0;
    for (int f = 0; f < NFRAMES; f++) begin
      sh_busy[f] = 1'b0;
      sh_live[f] = 0;
    end
    for (int c = 0; c < NCLASSES; c++) sh_part_head[c] = NIL;
    sh_total = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: a free before anything is allocated, every class boundary,
    // sizes that no class holds, a slot past the end of its slab, a plain free
    // that releases the frame, and a double free.
    send_free(0, 0);
    send_alloc(0);
    foreach (round_len[i]) ;
    for (int c = 0; c < NCLASSES; c++) begin
      send_alloc(16 << c);
      send_alloc((16 << c) + 1);
    end
    send_alloc(65535);
    send_alloc(32768);
    send_free(1, 255);
    send_free(63, 0);
    send_free(0, 0);
    send_free(0, 1);
    send_free(0, 1);
    send_alloc(1);
    send_alloc(16);
    while (pending_reqs.size() || start || owed_grants.size()) @(posedge clk);

    // Random part.
    total = 0;
    foreach (round_len[i]) total += round_len[i];
    sent = 0;
    for (round = 0; round < 4; round++) begin
      for (n = 0; n < round_len[round]; n++) begin
        while (pending_reqs.size() >= 2) @(posedge clk);
        if (sent >= total - QUIET_TAIL) quiet = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_free($urandom_range(0, 63), $urandom_range(0, 255));
        end else if (r < 8) begin
          send_alloc($urandom_range(0, 65535));
        end else if (r < 8 + alloc_pct[round] * 92 / 100) begin
          send_alloc(pick_size(lo_cls[round], NCLASSES - 1));
        end else begin
          send_live_free();
        end
        sent++;
      end
    end

    while (pending_reqs.size() || start || owed_grants.size()) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && owed_grants.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
